// ===== hw/rtl/sdf_pkg.sv =====
package sdf_pkg;

  // value is 32 bits, so its magnitude never has more than ten digits
  localparam int MAG_W      = 32;
  localparam int MAG_DIGITS = 10;
  // table entries carry two extra bits so a saturated multiple always compares high
  localparam int TAB_W      = MAG_W + 2;
  localparam int TOTAL_W    = 31;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SETUP = 3'b010,
    S_DIGIT = 3'b100
  } sdf_state_t;

  // k * 10^p, clipped to the table width
  function automatic logic [TAB_W-1:0] mult_val(input int p, input int k);
    longint unsigned v;
    v = longint'(k);
    for (int i = 0; i < p; i++) begin
      if (v > 64'h3_FFFF_FFFF) begin
        v = 64'h3_FFFF_FFFF;
      end else begin
        v = v * 10;
      end
    end
    if (v > 64'h3_FFFF_FFFF) begin
      v = 64'h3_FFFF_FFFF;
    end
    return v[TAB_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/signed_decimal_formatter.sv =====
// Signed decimal formatter: printf-style %d with '+' and ' ' flags.
// Input channel (in_valid / in_stall): value, force_plus, space_flag,
// min_digits (0 reads as 1, above MAX_DIGITS reads as MAX_DIGITS) and
// count_in, the characters already written.
// Result channel (out_valid / out_stall): one ASCII character per item,
// sign first if any, then digits most significant first, zero padded to
// min_digits. out_running_total counts up from count_in and saturates at
// 2^31-1; out_last marks the final digit.
// Sequence: the item is taken in S_IDLE; S_SETUP finds the digit count and
// loads the sign if any, then S_DIGIT sends one digit per cycle, unless the
// result side stalls, from a shared digit extractor (compare against the
// nine multiples of 10^pos). The digit count is max(digits of |value|,
// min_digits). The sign is registered into the output in S_SETUP and each
// digit in S_DIGIT; a stall on the result side can hold either.
// in_stall is high from accept until the last digit is loaded.
// A stall on the result side holds the output register and the sequencer;
// the next item may be accepted while the last character still waits.
// Reset clears the sequencer and drops out_valid.
module signed_decimal_formatter
  import sdf_pkg::*;
#(
  parameter int MAX_DIGITS = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [MAG_W-1:0]   in_value,
  input  logic                      in_force_plus,
  input  logic                      in_space_flag,
  input  logic [3:0]                in_min_digits,
  input  logic [TOTAL_W-1:0]        in_count_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_char,
  output logic [TOTAL_W-1:0]        out_running_total,
  output logic                      out_last
);

  localparam int POS_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  sdf_state_t         state_r, state_nxt;
  logic [MAG_W-1:0]   rem_r, rem_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   mind_r, mind_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [7:0]         sign_r, sign_nxt;
  logic               has_sign_r, has_sign_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         char_r, char_nxt;
  logic [TOTAL_W-1:0] otot_r, otot_nxt;
  logic               last_r, last_nxt;

  logic               in_fire;
  logic               out_free;
  logic [CNT_W-1:0]   nsig;
  logic [CNT_W-1:0]   ndig;
  logic [TOTAL_W-1:0] total_inc;
  logic [3:0]         digit;
  logic [MAG_W-1:0]   rem_sub;

  sdf_digit #(
    .MAX_DIGITS(MAX_DIGITS),
    .POS_W     (POS_W)
  ) u_digit (
    .rem    (rem_r),
    .pos    (pos_r),
    .digit  (digit),
    .rem_nxt(rem_sub)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign total_inc = (total_r == TOTAL_MAX) ? total_r : total_r + 1'b1;

  // significant digits of the magnitude
  always_comb begin
    nsig = CNT_W'(1);
    for (int p = 1; p < MAG_DIGITS; p++) begin
      if ({2'b00, rem_r} >= mult_val(p, 1)) begin
        nsig = CNT_W'(p + 1);
      end
    end
  end

  assign ndig = (nsig > mind_r) ? nsig : mind_r;

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    mind_nxt      = mind_r;
    total_nxt     = total_r;
    sign_nxt      = sign_r;
    has_sign_nxt  = has_sign_r;
    out_valid_nxt = out_valid_r && out_stall;
    char_nxt      = char_r;
    otot_nxt      = otot_r;
    last_nxt      = last_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          rem_nxt      = in_value[MAG_W-1] ? (~in_value + 32'd1) : in_value;
          total_nxt    = in_count_in;
          has_sign_nxt = in_value[MAG_W-1] || in_force_plus || in_space_flag;
          if (in_value[MAG_W-1]) begin
            sign_nxt = CH_MINUS;
          end else if (in_force_plus) begin
            sign_nxt = CH_PLUS;
          end else begin
            sign_nxt = CH_SPACE;
          end
          if (in_min_digits == 4'd0) begin
            mind_nxt = CNT_W'(1);
          end else if (32'(in_min_digits) > MAX_DIGITS) begin
            mind_nxt = CNT_W'(MAX_DIGITS);
          end else begin
            mind_nxt = CNT_W'(in_min_digits);
          end
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        if (out_free) begin
          pos_nxt   = POS_W'(ndig - 1'b1);
          state_nxt = S_DIGIT;
          if (has_sign_r) begin
            out_valid_nxt = 1'b1;
            char_nxt      = sign_r;
            otot_nxt      = total_inc;
            last_nxt      = 1'b0;
            total_nxt     = total_inc;
          end
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = CH_ZERO + {4'd0, digit};
          otot_nxt      = total_inc;
          last_nxt      = (pos_r == '0);
          total_nxt     = total_inc;
          rem_nxt       = rem_sub;
          pos_nxt       = pos_r - 1'b1;
          if (pos_r == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    pos_r      <= pos_nxt;
    mind_r     <= mind_nxt;
    total_r    <= total_nxt;
    sign_r     <= sign_nxt;
    has_sign_r <= has_sign_nxt;
    char_r     <= char_nxt;
    otot_r     <= otot_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_char          = char_r;
  assign out_running_total = otot_r;
  assign out_last          = last_r;

endmodule

// ===== hw/rtl/sdf_digit.sv =====
// One decimal digit per call: remainder must be below 10^(pos+1).
module sdf_digit
  import sdf_pkg::*;
#(
  parameter int MAX_DIGITS = 10,
  parameter int POS_W      = 4
) (
  input  logic [MAG_W-1:0] rem,
  input  logic [POS_W-1:0] pos,
  output logic [3:0]       digit,
  output logic [MAG_W-1:0] rem_nxt
);

  logic [TAB_W-1:0] tab [MAX_DIGITS][10];
  logic [TAB_W-1:0] row [10];
  logic [TAB_W-1:0] sub;

  for (genvar p = 0; p < MAX_DIGITS; p++) begin : g_pos
    for (genvar k = 0; k < 10; k++) begin : g_mult
      assign tab[p][k] = mult_val(p, k);
    end
  end

  assign row = tab[pos];

  // multiples are increasing, so the last one that fits wins
  always_comb begin
    digit = 4'd0;
    sub   = '0;
    for (int k = 1; k < 10; k++) begin
      if ({2'b00, rem} >= row[k]) begin
        digit = 4'(k);
        sub   = row[k];
      end
    end
  end

  assign rem_nxt = rem - sub[MAG_W-1:0];

endmodule

// ===== hw/rtl/sdf_checker.sv =====
module sdf_checker
  import sdf_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [7:0]         out_char,
  input logic [TOTAL_W-1:0] out_running_total,
  input logic               out_last
);

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) &&
      $stable(out_running_total) && $stable(out_last))
    else $error("stalled result changed");

  // only one item in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // a sign character is never the final one
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char == CH_PLUS || out_char == CH_SPACE ||
      out_char == CH_MINUS) |-> !out_last)
    else $error("sign marked last");

  // a sign only opens a conversion; the next character is a digit
  a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_char == CH_PLUS ||
      out_char == CH_SPACE || out_char == CH_MINUS) |=>
      !out_valid || (out_char >= CH_ZERO && out_char <= 8'h39))
    else $error("sign not followed by digit");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind signed_decimal_formatter sdf_checker u_sdf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_char         (out_char),
  .out_running_total(out_running_total),
  .out_last         (out_last)
);

// ===== bench/tb.sv =====
module tb;
  import sdf_pkg::*;

  localparam int FMT_MAX_DIGITS = 10;

  typedef struct {
    logic signed [MAG_W-1:0] value;
    logic                    force_plus;
    logic                    space_flag;
    logic [3:0]              min_digits;
    logic [TOTAL_W-1:0]      count_in;
  } conv_req_t;

  typedef struct {
    logic [7:0]         ch;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } fmt_char_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [MAG_W-1:0] in_value;
  logic                    in_force_plus;
  logic                    in_space_flag;
  logic [3:0]              in_min_digits;
  logic [TOTAL_W-1:0]      in_count_in;
  logic                    out_valid;
  logic                    out_stall;
  logic [7:0]              out_char;
  logic [TOTAL_W-1:0]      out_running_total;
  logic                    out_last;

  fmt_char_t pending_chars[$];
  fmt_char_t want;
  int        mismatches;
  bit        tx_idle_on;
  bit        rx_idle_on;
  bit        hold_req;
  int        hold_cycles;
  int        stall_left;

  signed_decimal_formatter #(
    .MAX_DIGITS(FMT_MAX_DIGITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_force_plus    (in_force_plus),
    .in_space_flag    (in_space_flag),
    .in_min_digits    (in_min_digits),
    .in_count_in      (in_count_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_running_total(out_running_total),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  // Expected characters of one conversion, pushed in emission order
  function automatic void format_decimal(input conv_req_t r);
    logic [MAG_W-1:0]   mag;
    logic [3:0]         digs [0:FMT_MAX_DIGITS-1];
    int                 nsig;
    int                 ndig;
    int                 mind;
    logic [TOTAL_W-1:0] total;
    fmt_char_t          c;
    mag = r.value;
    if (r.value[MAG_W-1]) begin
      mag = ~mag + 32'd1;
    end
    mind = int'(r.min_digits);
    if (mind < 1) begin
      mind = 1;
    end
    if (mind > FMT_MAX_DIGITS) begin
      mind = FMT_MAX_DIGITS;
    end
    nsig = 0;
    do begin
      digs[nsig] = 4'(mag % 10);
      mag = mag / 10;
      nsig++;
    end while (mag != 0);
    ndig = (nsig > mind) ? nsig : mind;
    for (int i = nsig; i < ndig; i++) begin
      digs[i] = 4'd0;
    end
    total = r.count_in;
    if (r.value[MAG_W-1] || r.force_plus || r.space_flag) begin
      if (total != TOTAL_MAX) begin
        total++;
      end
      c.ch = r.value[MAG_W-1] ? CH_MINUS : (r.force_plus ? CH_PLUS : CH_SPACE);
      c.total = total;
      c.last = 1'b0;
      pending_chars.push_back(c);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      if (total != TOTAL_MAX) begin
        total++;
      end
      c.ch = CH_ZERO + 8'(digs[i]);
      c.total = total;
      c.last = (i == 0);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic conv_req_t conv(input logic signed [MAG_W-1:0] v, input bit plus,
                                     input bit space, input int mind, input int cnt);
    conv_req_t r;
    r.value = v;
    r.force_plus = plus;
    r.space_flag = space;
    r.min_digits = 4'(mind);
    r.count_in = TOTAL_W'(cnt);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 30);
  endfunction

  task automatic offer_conversion(input conv_req_t r);
    int gap;
    @(negedge clk);
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_value = r.value;
    in_force_plus = r.force_plus;
    in_space_flag = r.space_flag;
    in_min_digits = r.min_digits;
    in_count_in = r.count_in;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    format_decimal(r);
  endtask

  // Receiver side: random stalls, plus a counted hold when requested
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = hold_cycles;
      end
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (!rx_idle_on || $urandom_range(0, 99) < 75) begin
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected char: char=%h total=%0d last=%b", out_char,
                   out_running_total, out_last);
        end
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch || out_running_total !== want.total ||
            out_last !== want.last) begin
          if (mismatches < 10) begin
            $display("char mismatch: exp char=%h total=%0d last=%b, got char=%h total=%0d last=%b",
                     want.ch, want.total, want.last, out_char, out_running_total, out_last);
          end
          mismatches++;
        end
      end
    end
  end

  task automatic test_sign_and_flags();
    offer_conversion(conv(32'sd42, 1'b0, 1'b0, 1, 0));
    offer_conversion(conv(32'sd42, 1'b1, 1'b0, 1, 5));
    offer_conversion(conv(32'sd42, 1'b0, 1'b1, 1, 7));
    offer_conversion(conv(32'sd0, 1'b1, 1'b1, 1, 9));
    offer_conversion(conv(-32'sd42, 1'b1, 1'b1, 1, 3));
    offer_conversion(conv(-32'sd7, 1'b0, 1'b0, 3, 0));
  endtask

  task automatic test_digit_padding();
    offer_conversion(conv(32'sd5, 1'b0, 1'b0, 0, 0));
    offer_conversion(conv(32'sd5, 1'b0, 1'b0, 1, 0));
    offer_conversion(conv(32'sd123, 1'b1, 1'b0, 5, 11));
    offer_conversion(conv(-32'sd123, 1'b0, 1'b0, 10, 20));
    offer_conversion(conv(32'sd9, 1'b0, 1'b1, 11, 0));
    offer_conversion(conv(32'sd12345, 1'b0, 1'b0, 15, 100));
    offer_conversion(conv(32'sd987654, 1'b0, 1'b0, 2, 0));
  endtask

  task automatic test_extreme_values();
    offer_conversion(conv(32'sh8000_0000, 1'b1, 1'b1, 1, 0));
    offer_conversion(conv(32'sh7FFF_FFFF, 1'b1, 1'b0, 15, 0));
    offer_conversion(conv(-32'sd1, 1'b0, 1'b0, 10, 0));
    offer_conversion(conv(32'sd1000000000, 1'b0, 1'b1, 1, 0));
    offer_conversion(conv(32'sd999999999, 1'b0, 1'b0, 10, 0));
  endtask

  task automatic test_total_saturation();
    offer_conversion(conv(32'sd77, 1'b1, 1'b0, 1, int'(TOTAL_MAX)));
    offer_conversion(conv(-32'sd4321, 1'b0, 1'b0, 1, int'(TOTAL_MAX) - 3));
    offer_conversion(conv(32'sh8000_0000, 1'b0, 1'b0, 10, int'(TOTAL_MAX) - 11));
  endtask

  function automatic logic signed [MAG_W-1:0] rand_value();
    longint p10;
    longint v;
    p10 = 1;
    repeat ($urandom_range(0, 9)) p10 = p10 * 10;
    case ($urandom_range(0, 5))
      0, 5: v = longint'($signed($urandom()));
      1: v = $urandom_range(0, 999);
      2: v = p10 + longint'($urandom_range(0, 2)) - 1;
      3: v = 2147483647 - longint'($urandom_range(0, 3));
      default: v = longint'($urandom()) % p10;
    endcase
    // magnitude cases pick a random sign; 2^31 itself wraps to the most negative
    if ($urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return MAG_W'(v);
  endfunction

  function automatic conv_req_t rand_conversion();
    conv_req_t r;
    int        k;
    r.value = rand_value();
    r.force_plus = 1'($urandom_range(0, 1));
    r.space_flag = 1'($urandom_range(0, 1));
    r.min_digits = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(1, 10));
    k = $urandom_range(0, 4);
    if (k < 3) begin
      r.count_in = TOTAL_W'($urandom_range(0, 1000));
    end else if (k == 3) begin
      r.count_in = TOTAL_W'($urandom());
    end else begin
      r.count_in = TOTAL_MAX - TOTAL_W'($urandom_range(0, 15));
    end
    return r;
  endfunction

  task automatic test_output_holdoff();
    tx_idle_on = 1'b0;
    hold_cycles = 80;
    hold_req = 1'b1;
    repeat (10) offer_conversion(rand_conversion());
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_conversions(input int n, input bit idle);
    tx_idle_on = idle;
    rx_idle_on = idle;
    repeat (n) offer_conversion(rand_conversion());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    in_force_plus = 1'b0;
    in_space_flag = 1'b0;
    in_min_digits = 4'd1;
    in_count_in = '0;
    mismatches = 0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_req = 1'b0;
    hold_cycles = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_sign_and_flags();
    test_digit_padding();
    test_extreme_values();
    test_total_saturation();
    test_random_conversions(60, 1'b0);
    test_random_conversions(150, 1'b1);
    test_output_holdoff();
    test_random_conversions(145, 1'b1);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * 1000000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sdf_pkg.sv
hw/rtl/sdf_digit.sv
hw/rtl/signed_decimal_formatter.sv
hw/rtl/sdf_checker.sv
bench/tb.sv
